// ===== rtl/b64d_pkg.sv =====
// Shared types, constants and the symbol lookup for the base64 stream decoder.
`default_nettype none
package b64d_pkg;

  localparam int SYM_W       = 7;   // symbol values 0..64
  localparam int ACC_W       = 26;  // shift accumulator width
  localparam int PHASE_W     = 2;   // symbols / characters mod 4
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_FOURTH = 2'd3;

  // Raw character transaction
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } chr_t;

  // Decoded result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_flag;
    logic       length_error;
  } dec_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sym_ok;   // decodable symbol, decoder not halted
    logic             last;
    logic             len_err;
  } cls_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } sym_lookup_t;

  // Alphabet: a-z, A-N, '0', P-Z, 'O', 1-9, '+', '/', '='
  function automatic sym_lookup_t sym_lookup(input logic [7:0] c);
    sym_lookup_t r;
    r.hit = 1'b1;
    r.sym = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r.sym = SYM_W'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h4e) begin
      r.sym = SYM_W'(c - 8'h41 + 8'd26);
    end else if (c == 8'h30) begin
      r.sym = SYM_W'(40);
    end else if (c >= 8'h50 && c <= 8'h5a) begin
      r.sym = SYM_W'(c - 8'h50 + 8'd41);
    end else if (c == 8'h4f) begin
      r.sym = SYM_W'(52);
    end else if (c >= 8'h31 && c <= 8'h39) begin
      r.sym = SYM_W'(c - 8'h31 + 8'd53);
    end else if (c == 8'h2b) begin
      r.sym = SYM_W'(62);
    end else if (c == 8'h2f) begin
      r.sym = SYM_W'(63);
    end else if (c == 8'h3d) begin
      r.sym = SYM_W'(64);
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_front.sv =====
// Front end: accepts characters, tracks length and halt, classifies symbols.
`default_nettype none
module b64d_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           chr_valid,
  output logic                chr_ready,
  input  wire b64d_pkg::chr_t chr,
  input  wire logic           q_full,
  output logic                push,
  output b64d_pkg::cls_t      push_item
);
  import b64d_pkg::*;

  logic [PHASE_W-1:0] len_phase;
  logic [PHASE_W-1:0] len_phase_next;
  logic               halted;
  logic               halt_now;
  sym_lookup_t        lk;

  assign chr_ready = !q_full;
  assign push      = chr_valid && chr_ready;

  // Classification
  always_comb begin
    len_phase_next   = len_phase + 1'b1;
    halt_now         = halted || (chr.char_code == 8'h00);
    lk               = sym_lookup(chr.char_code);
    push_item.sym    = lk.sym;
    push_item.sym_ok = lk.hit && !halt_now;
    push_item.last   = chr.last_char;
    push_item.len_err = chr.last_char && (len_phase_next == PHASE_SECOND);
  end

  // Per-message length and halt state
  always_ff @(posedge clk) begin
    if (rst) begin
      len_phase <= PHASE_FIRST;
      halted    <= 1'b0;
    end else if (push) begin
      if (chr.last_char) begin
        len_phase <= PHASE_FIRST;
        halted    <= 1'b0;
      end else begin
        len_phase <= len_phase_next;
        halted    <= halt_now;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_queue.sv =====
// Short FIFO of classified characters between front and back.
`default_nettype none
module b64d_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64d_pkg::cls_t push_item,
  input  wire logic           pop,
  output b64d_pkg::cls_t      pop_item,
  output logic                full,
  output logic                empty
);
  import b64d_pkg::*;

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_back.sv =====
// Back end: shift-accumulates symbols, extracts bytes, holds the output register.
`default_nettype none
module b64d_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire b64d_pkg::cls_t q_item,
  output logic                pop,
  output logic                dec_valid,
  input  wire logic           dec_ready,
  output b64d_pkg::dec_t      dec
);
  import b64d_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [PHASE_W-1:0] sym_phase;
  logic [PHASE_W-1:0] sym_phase_next;
  dec_t               result;

  // Drain the queue whenever the output register is free or being taken
  assign pop = !q_empty && (!dec_valid || dec_ready);

  // Accumulate and pick the byte for the new phase
  always_comb begin
    sym_phase_next = sym_phase + 1'b1;
    if (sym_phase == PHASE_FIRST) begin
      acc_next = ACC_W'(q_item.sym);
    end else begin
      acc_next = ACC_W'({acc, 6'b0}) + ACC_W'(q_item.sym);
    end
    result.out_byte     = 8'h00;
    result.byte_valid   = 1'b0;
    result.end_flag     = q_item.last;
    result.length_error = q_item.len_err;
    if (q_item.sym_ok) begin
      case (sym_phase_next)
        PHASE_THIRD: begin
          result.out_byte   = acc_next[11:4];
          result.byte_valid = 1'b1;
        end
        PHASE_FOURTH: begin
          result.out_byte   = acc_next[9:2];
          result.byte_valid = 1'b1;
        end
        PHASE_FIRST: begin
          result.out_byte   = acc_next[7:0];
          result.byte_valid = 1'b1;
        end
        default: begin
          result.byte_valid = 1'b0;
        end
      endcase
    end
  end

  // Decoder state, cleared at end of message
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sym_phase <= PHASE_FIRST;
    end else if (pop) begin
      if (q_item.last) begin
        acc       <= '0;
        sym_phase <= PHASE_FIRST;
      end else if (q_item.sym_ok) begin
        acc       <= acc_next;
        sym_phase <= sym_phase_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (pop) begin
      dec_valid <= 1'b1;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dec <= result;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder_unit.sv =====
// Path: an accepted character goes into the queue, then into the output register.
// Throughput: one character per cycle unless the queue fills; the two-entry queue
//   and the output register let input and output stall independently.
// Back end sets rate: one symbol accumulate, byte select per cycle unless stalled.
// Reset (rst, synchronous): empties the queue and output, clears all decoder state.
`default_nettype none
module base64_stream_decoder_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           chr_valid,
  output logic                chr_ready,
  input  wire b64d_pkg::chr_t chr,
  output logic                dec_valid,
  input  wire logic           dec_ready,
  output b64d_pkg::dec_t      dec
);
  import b64d_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cls_t push_item;
  cls_t pop_item;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

endmodule
`default_nettype wire

// ===== rtl/b64d_checker.sv =====
// Port-level checks for the decoder, bound to the top level.
`default_nettype none
module b64d_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           chr_valid,
  input wire logic           chr_ready,
  input wire b64d_pkg::chr_t chr,
  input wire logic           dec_valid,
  input wire logic           dec_ready,
  input wire b64d_pkg::dec_t dec
);
  import b64d_pkg::*;

  // A stalled result transaction holds
  a_dec_hold: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec))
    else $error("result changed while stalled");

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !dec_valid)
    else $error("result valid after reset");

  // A length error only comes with the end of message
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec.length_error |-> dec.end_flag)
    else $error("length error without end flag");

  // Bytes not produced read as zero
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec.byte_valid |-> dec.out_byte == 8'h00)
    else $error("nonzero byte without byte_valid");

  // A character accepted into an idle block passes the queue and raises dec_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr_ready && !dec_valid |=> ##1 dec_valid)
    else $error("accepted character produced no result");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .chr_valid (chr_valid),
  .chr_ready (chr_ready),
  .chr       (chr),
  .dec_valid (dec_valid),
  .dec_ready (dec_ready),
  .dec       (dec)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the base64 stream decoder unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  logic clk;
  logic rst       = 1'b1;
  logic chr_valid = 1'b0;
  logic chr_ready;
  chr_t chr       = '0;
  logic dec_valid;
  logic dec_ready = 1'b0;
  dec_t dec;

  base64_stream_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr       (chr),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  // Alphabet in symbol order; '0' and 'O' are swapped, '=' is symbol 64
  string alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMN0PQRSTUVWXYZO123456789+/=";

  // Decoder state as predicted by the testbench
  logic [25:0] acc_model;
  logic [1:0]  sym_phase_model;
  logic [1:0]  len_phase_model;
  logic        halted_model;

  dec_t decoded_q[$];   // expected results, oldest first

  bit in_quiet;         // sender never idles
  bit out_quiet;        // receiver never stalls
  int err_count;
  int results_checked;
  int bytes_seen;
  int len_errs_seen;
  int messages_sent;
  int stream_items;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Symbol value of a character, -1 when it is not in the alphabet
  function automatic int symbol_value(input logic [7:0] c);
    if (c >= "a" && c <= "z") return int'(c) - int'("a");
    if (c >= "A" && c <= "N") return 26 + int'(c) - int'("A");
    if (c == "0")             return 40;
    if (c >= "P" && c <= "Z") return 41 + int'(c) - int'("P");
    if (c == "O")             return 52;
    if (c >= "1" && c <= "9") return 53 + int'(c) - int'("1");
    if (c == "+")             return 62;
    if (c == "/")             return 63;
    if (c == "=")             return 64;
    return -1;
  endfunction

  function automatic void clear_decoder();
    acc_model       = '0;
    sym_phase_model = '0;
    len_phase_model = '0;
    halted_model    = 1'b0;
  endfunction

  // Advance the predicted state by one character and return its result
  function automatic dec_t decode_char(input chr_t c);
    dec_t        r;
    int          s;
    logic [31:0] wide;
    r = '0;
    len_phase_model = len_phase_model + 2'd1;
    if (c.char_code == 8'h00) halted_model = 1'b1;
    if (!halted_model) begin
      s = symbol_value(c.char_code);
      if (s >= 0) begin
        if (sym_phase_model == PHASE_FIRST) begin
          acc_model = 26'(s);
        end else begin
          wide = ({6'b0, acc_model} << 6) + 32'(s);
          acc_model = wide[25:0];
        end
        sym_phase_model = sym_phase_model + 2'd1;
        // byte taken from a window that slides down with the phase
        case (sym_phase_model)
          PHASE_THIRD: begin
            r.out_byte = acc_model[11:4];
            r.byte_valid = 1'b1;
          end
          PHASE_FOURTH: begin
            r.out_byte = acc_model[9:2];
            r.byte_valid = 1'b1;
          end
          PHASE_FIRST: begin
            r.out_byte = acc_model[7:0];
            r.byte_valid = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (c.last_char) begin
      r.end_flag = 1'b1;
      r.length_error = (len_phase_model == 2'd1);
      clear_decoder();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 100)
      $display("MISMATCH %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
  endtask

  // Drive one character transaction; entered and left at a falling edge
  task automatic send_char(input logic [7:0] code, input logic last);
    chr_t item;
    int   gap;
    item.char_code = code;
    item.last_char = last;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      chr_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chr_valid <= 1'b1;
    chr <= item;
    do @(posedge clk); while (!chr_ready);
    decoded_q.push_back(decode_char(item));
    if (last) messages_sent++;
    @(negedge clk);
  endtask

  // Whole message, last flag on the final character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  // Receiver: random stall before each result
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        dec_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dec_ready <= 1'b1;
      do @(posedge clk); while (!dec_valid);
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    dec_t want;
    if (!rst && dec_valid && dec_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result", int'(dec), 0);
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (want.byte_valid) bytes_seen++;
        if (want.length_error) len_errs_seen++;
        if (dec.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(dec.out_byte), int'(want.out_byte));
        if (dec.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", int'(dec.byte_valid), int'(want.byte_valid));
        if (dec.end_flag !== want.end_flag)
          report_mismatch("end_flag", int'(dec.end_flag), int'(want.end_flag));
        if (dec.length_error !== want.length_error)
          report_mismatch("length_error", int'(dec.length_error),
                          int'(want.length_error));
      end
    end
  end

  // Alphabet boundaries, swapped pair and '=' in one 13-char message
  task automatic test_alphabet_extremes();
    send_text("azANP0ZO19+/=");
  endtask

  // Stray characters are skipped; a zero halts decoding until the end
  task automatic test_skip_and_halt();
    send_char("q", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("W", 1'b0);
    send_char("=", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b1);
  endtask

  // One-char message (length error) and a two-char message of '/' and '='
  task automatic test_short_messages();
    send_text("=");
    send_text("/=");
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 8)
      return alphabet[$urandom_range(0, 64)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Random messages: mostly short, some long, some cut by a zero
  task automatic test_random_stream();
    int         len;
    int         zero_at;
    logic [7:0] code;
    while (stream_items < 1300) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: begin in_quiet = 1'b1; out_quiet = 1'b1; end
          1: begin in_quiet = 1'b1; out_quiet = 1'b0; end
          2: begin in_quiet = 1'b0; out_quiet = 1'b1; end
          default: begin in_quiet = 1'b0; out_quiet = 1'b0; end
        endcase
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 16);
      zero_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        code = (i == zero_at) ? 8'h00 : pick_char();
        stream_items++;
        send_char(code, i == len - 1);
      end
    end
  endtask

  initial begin
    clear_decoder();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_alphabet_extremes();
    test_skip_and_halt();
    test_short_messages();
    test_random_stream();

    chr_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d messages: %0d results checked, %0d bytes, %0d length errors",
             messages_sent, results_checked, bytes_seen, len_errs_seen);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results pending", decoded_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
